>>> design/fresnel_pkg.sv
// ----------------------------------------------------------------------------
// fresnel_pkg
// Types, constants and helper functions for the Fresnel boundary event core.
// ----------------------------------------------------------------------------
package fresnel_pkg;

   localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
   localparam logic [32:0] ONE_Q32  = 33'h1_0000_0000;
   localparam int          DivStages  = 34;
   localparam int          SqrtStages = 32;

   typedef struct packed {
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_z;
      logic [15:0]        index_here;
      logic [15:0]        index_beyond;
      logic [31:0]        random_fraction;
   } fresnel_req_type;

   typedef struct packed {
      logic signed [31:0] new_dir_x;
      logic signed [31:0] new_dir_y;
      logic signed [31:0] new_dir_z;
      logic               transmitted;
   } fresnel_rsp_type;

   typedef struct packed {
      fresnel_req_type req;
      logic            tir;
      logic [30:0]     b;
      logic            fguard;
      logic [47:0]     numx;
      logic [47:0]     numy;
   } fresnel_meta_type;

   function automatic logic [31:0] abs32(input logic [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

   function automatic logic [30:0] clamp_q30(input logic [31:0] m);
      return (m > {1'b0, ONE_Q30}) ? ONE_Q30 : m[30:0];
   endfunction

   // right shift that brings a denominator below 2^32
   function automatic logic [3:0] norm_shift(input logic [47:0] den);
      logic [3:0] k;
      k = 4'd0;
      for (int i = 32; i < 47; i++) begin
         if (den[i]) k = 4'(i - 31);
      end
      return k;
   endfunction

endpackage

>>> design/fresnel_div.sv
// ----------------------------------------------------------------------------
// fresnel_div
// Pipelined restoring divider: 64-bit dividend, 32-bit divisor, 33 quotient
// bits, one bit per stage, with an overflow flag and a side-band payload.
// ----------------------------------------------------------------------------
module fresnel_div
   import fresnel_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [63:0]      in_num,
   input  logic [31:0]      in_den,
   input  fresnel_meta_type in_side,
   output logic             out_valid,
   output logic [32:0]      out_quot,
   output logic             out_ovf,
   output fresnel_meta_type out_side
);

   logic             valid_ff [0:DivStages-1];
   logic [63:0]      rem_ff   [0:DivStages-2];
   logic [31:0]      den_ff   [0:DivStages-2];
   logic [32:0]      quot_ff  [0:DivStages-1];
   logic             ovf_ff   [0:DivStages-1];
   fresnel_meta_type side_ff  [0:DivStages-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= in_num;
         den_ff[0]  <= in_den;
         quot_ff[0] <= '0;
         ovf_ff[0]  <= {1'b0, in_num} >= {in_den, 33'd0};
         side_ff[0] <= in_side;
      end
   end

   for (genvar j = 1; j < DivStages; j++) begin : g_stage
      logic [64:0] trial;
      logic [63:0] rem_in;
      logic [32:0] quot_in;

      always_comb begin
         trial   = 65'(den_ff[j-1]) << (DivStages - 1 - j);
         rem_in  = rem_ff[j-1];
         quot_in = quot_ff[j-1];
         if ({1'b0, rem_ff[j-1]} >= trial) begin
            rem_in = rem_ff[j-1] - trial[63:0];
            quot_in[DivStages-1-j] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (en) begin
            valid_ff[j] <= valid_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            quot_ff[j] <= quot_in;
            ovf_ff[j]  <= ovf_ff[j-1];
            side_ff[j] <= side_ff[j-1];
         end
      end

      if (j < DivStages - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j] <= rem_in;
               den_ff[j] <= den_ff[j-1];
            end
         end
      end
   end

   assign out_valid = valid_ff[DivStages-1];
   assign out_quot  = quot_ff[DivStages-1];
   assign out_ovf   = ovf_ff[DivStages-1];
   assign out_side  = side_ff[DivStages-1];

endmodule

>>> design/fresnel_isqrt.sv
// ----------------------------------------------------------------------------
// fresnel_isqrt
// Pipelined integer square root of a 62-bit value, one result bit per stage,
// with a side-band payload.
// ----------------------------------------------------------------------------
module fresnel_isqrt
   import fresnel_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [61:0]      in_x,
   input  fresnel_meta_type in_side,
   output logic             out_valid,
   output logic [30:0]      out_root,
   output fresnel_meta_type out_side
);

   logic             valid_ff [0:SqrtStages-1];
   logic [61:0]      x_ff     [0:SqrtStages-2];
   logic [61:0]      r_ff     [0:SqrtStages-1];
   fresnel_meta_type side_ff  [0:SqrtStages-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= in_x;
         r_ff[0]    <= '0;
         side_ff[0] <= in_side;
      end
   end

   for (genvar j = 1; j < SqrtStages; j++) begin : g_stage
      logic [61:0] bitv;
      logic [61:0] trial;
      logic [61:0] x_in;
      logic [61:0] r_in;

      always_comb begin
         bitv  = 62'd1 << (62 - 2 * j);
         trial = r_ff[j-1] + bitv;
         if (x_ff[j-1] >= trial) begin
            x_in = x_ff[j-1] - trial;
            r_in = (r_ff[j-1] >> 1) + bitv;
         end else begin
            x_in = x_ff[j-1];
            r_in = r_ff[j-1] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (en) begin
            valid_ff[j] <= valid_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[j]    <= r_in;
            side_ff[j] <= side_ff[j-1];
         end
      end

      if (j < SqrtStages - 1) begin : g_x
         always_ff @(posedge clock) begin
            if (en) begin
               x_ff[j] <= x_in;
            end
         end
      end
   end

   assign out_valid = valid_ff[SqrtStages-1];
   assign out_root  = r_ff[SqrtStages-1][30:0];
   assign out_side  = side_ff[SqrtStages-1];

endmodule

>>> design/fresnel_reflect_or_transmit_core.sv
// ----------------------------------------------------------------------------
// fresnel_reflect_or_transmit_core
// Throughput: one transaction per cycle; the whole pipeline stalls together
// while the response register is full and not taken.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module fresnel_reflect_or_transmit_core
   import fresnel_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  fresnel_req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output fresnel_rsp_type rsp_data
);

   logic adv;
   logic rsp_valid_ff;
   fresnel_rsp_type rsp_data_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // stage 1: cosine magnitude, index squares, scale numerators
   logic             v1_ff;
   fresnel_meta_type m1_ff, m1_in;
   logic [30:0]      a1_ff;
   logic [31:0]      n1sq1_ff, n2sq1_ff;

   always_comb begin
      m1_in        = '0;
      m1_in.req    = req_data;
      m1_in.numx   = {16'd0, abs32(req_data.dir_x)} * {32'd0, req_data.index_here};
      m1_in.numy   = {16'd0, abs32(req_data.dir_y)} * {32'd0, req_data.index_here};
   end

   // stage 2: sine squared
   logic             v2_ff;
   fresnel_meta_type m2_ff;
   logic [30:0]      s2_ff, s2_in;
   logic [31:0]      n1sq2_ff, n2sq2_ff;
   logic [62:0]      sprod;

   always_comb begin
      sprod = 63'(ONE_Q30 - a1_ff) * 63'({1'b0, ONE_Q30} + {1'b0, a1_ff});
      s2_in = sprod[60:30];
   end

   // stage 3: Snell numerator
   logic             v3_ff;
   fresnel_meta_type m3_ff;
   logic [62:0]      qnum3_ff;
   logic [31:0]      n2sq3_ff;

   logic             vq;
   logic [32:0]      qd;
   logic             qovf;
   fresnel_meta_type mq;

   fresnel_div u_div_q (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (v3_ff),
      .in_num    ({1'b0, qnum3_ff}),
      .in_den    (n2sq3_ff),
      .in_side   (m3_ff),
      .out_valid (vq),
      .out_quot  (qd),
      .out_ovf   (qovf),
      .out_side  (mq)
   );

   // stage 4: total internal reflection test, square root operand
   logic             v4_ff;
   fresnel_meta_type m4_ff, m4_in;
   logic [61:0]      sq4_ff, sq4_in;

   always_comb begin
      m4_in     = mq;
      m4_in.tir = qovf || (qd > {2'b00, ONE_Q30});
      sq4_in    = m4_in.tir ? 62'd0 : {1'b0, ONE_Q30 - qd[30:0], 30'd0};
   end

   logic             vs;
   logic [30:0]      root;
   fresnel_meta_type ms;

   fresnel_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (v4_ff),
      .in_x      (sq4_ff),
      .in_side   (m4_ff),
      .out_valid (vs),
      .out_root  (root),
      .out_side  (ms)
   );

   // stage 5: Fresnel products
   logic             v5_ff;
   fresnel_meta_type m5_ff, m5_in;
   logic [46:0]      n1a5_ff, n2b5_ff, n2a5_ff, n1b5_ff;
   logic [30:0]      a5;

   always_comb begin
      m5_in   = ms;
      m5_in.b = root;
      a5      = clamp_q30(abs32(ms.req.dir_z));
   end

   // stage 6: sums and differences
   logic             v6_ff;
   fresnel_meta_type m6_ff, m6_in;
   logic [47:0]      ds6_ff, dp6_ff, ds6_in, dp6_in;
   logic [46:0]      ns6_ff, np6_ff;

   always_comb begin
      ds6_in       = {1'b0, n1a5_ff} + {1'b0, n2b5_ff};
      dp6_in       = {1'b0, n2a5_ff} + {1'b0, n1b5_ff};
      m6_in        = m5_ff;
      m6_in.fguard = (ds6_in == 48'd0) || (dp6_in == 48'd0);
   end

   // stage 7: normalize the ratio operands
   logic             v7_ff;
   fresnel_meta_type m7_ff;
   logic [31:0]      ns7_ff, ds7_ff, np7_ff, dp7_ff;
   logic [3:0]       ks, kp;

   always_comb begin
      ks = norm_shift(ds6_ff);
      kp = norm_shift(dp6_ff);
   end

   logic             vd;
   logic [32:0]      rs_q, rp_q, qx, qy;
   logic             unused_ovf_s, unused_ovf_p, ovfx, ovfy;
   fresnel_meta_type md;

   fresnel_div u_div_s (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (v7_ff),
      .in_num    ({ns7_ff, 32'd0}),
      .in_den    (ds7_ff),
      .in_side   (m7_ff),
      .out_valid (vd),
      .out_quot  (rs_q),
      .out_ovf   (unused_ovf_s),
      .out_side  (md)
   );

   fresnel_div u_div_p (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (v7_ff),
      .in_num    ({np7_ff, 32'd0}),
      .in_den    (dp7_ff),
      .in_side   ('0),
      .out_valid (),
      .out_quot  (rp_q),
      .out_ovf   (unused_ovf_p),
      .out_side  ()
   );

   fresnel_div u_div_x (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (v7_ff),
      .in_num    ({16'd0, m7_ff.numx}),
      .in_den    ({16'd0, m7_ff.req.index_beyond}),
      .in_side   ('0),
      .out_valid (),
      .out_quot  (qx),
      .out_ovf   (ovfx),
      .out_side  ()
   );

   fresnel_div u_div_y (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (v7_ff),
      .in_num    ({16'd0, m7_ff.numy}),
      .in_den    ({16'd0, m7_ff.req.index_beyond}),
      .in_side   ('0),
      .out_valid (),
      .out_quot  (qy),
      .out_ovf   (ovfy),
      .out_side  ()
   );

   // stage 8: square the ratios
   logic             v8_ff;
   fresnel_meta_type m8_ff;
   logic [32:0]      rs8_ff, rp8_ff, qx8_ff, qy8_ff;
   logic             ovfx8_ff, ovfy8_ff;
   logic [63:0]      rs_sq, rp_sq;
   logic [32:0]      rs8_in, rp8_in;

   always_comb begin
      rs_sq  = 64'(rs_q[31:0]) * 64'(rs_q[31:0]);
      rp_sq  = 64'(rp_q[31:0]) * 64'(rp_q[31:0]);
      rs8_in = (rs_q >= ONE_Q32) ? ONE_Q32 : {1'b0, rs_sq[63:32]};
      rp8_in = (rp_q >= ONE_Q32) ? ONE_Q32 : {1'b0, rp_sq[63:32]};
   end

   // stage 9: decision and result
   function automatic logic [31:0] sat_scale(input logic neg, input logic [32:0] q,
                                             input logic ovf);
      logic [31:0] r;
      if (!neg) begin
         r = (ovf || q > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
      end else begin
         r = (ovf || q > 33'h0_8000_0000) ? 32'h8000_0000 : (~q[31:0] + 32'd1);
      end
      return r;
   endfunction

   logic [33:0]     rsum;
   logic [32:0]     refl;
   logic            do_reflect;
   logic [31:0]     zb;
   fresnel_rsp_type rsp_in;

   always_comb begin
      rsum = {1'b0, rs8_ff} + {1'b0, rp8_ff};
      if (m8_ff.req.index_beyond == 16'd0 || m8_ff.tir || m8_ff.fguard) begin
         refl = ONE_Q32;
      end else begin
         refl = rsum[33:1];
      end
      do_reflect = {1'b0, m8_ff.req.random_fraction} <= refl;
      zb         = {1'b0, m8_ff.b};
      if (do_reflect) begin
         rsp_in.new_dir_x   = m8_ff.req.dir_x;
         rsp_in.new_dir_y   = m8_ff.req.dir_y;
         rsp_in.new_dir_z   = (m8_ff.req.dir_z == 32'sh8000_0000) ? 32'sh7FFF_FFFF
                                                                   : -m8_ff.req.dir_z;
         rsp_in.transmitted = 1'b0;
      end else begin
         rsp_in.new_dir_x   = sat_scale(m8_ff.req.dir_x[31], qx8_ff, ovfx8_ff);
         rsp_in.new_dir_y   = sat_scale(m8_ff.req.dir_y[31], qy8_ff, ovfy8_ff);
         rsp_in.new_dir_z   = (!m8_ff.req.dir_z[31] && m8_ff.req.dir_z != 32'sd0)
                              ? zb : (~zb + 32'd1);
         rsp_in.transmitted = 1'b1;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         v7_ff        <= 1'b0;
         v8_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= req_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= vq;
         v5_ff        <= vs;
         v6_ff        <= v5_ff;
         v7_ff        <= v6_ff;
         v8_ff        <= vd;
         rsp_valid_ff <= v8_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv) begin
         m1_ff       <= m1_in;
         a1_ff       <= clamp_q30(abs32(req_data.dir_z));
         n1sq1_ff    <= 32'(req_data.index_here) * 32'(req_data.index_here);
         n2sq1_ff    <= 32'(req_data.index_beyond) * 32'(req_data.index_beyond);

         m2_ff       <= m1_ff;
         s2_ff       <= s2_in;
         n1sq2_ff    <= n1sq1_ff;
         n2sq2_ff    <= n2sq1_ff;

         m3_ff       <= m2_ff;
         qnum3_ff    <= 63'(n1sq2_ff) * 63'(s2_ff);
         n2sq3_ff    <= n2sq2_ff;

         m4_ff       <= m4_in;
         sq4_ff      <= sq4_in;

         m5_ff       <= m5_in;
         n1a5_ff     <= 47'(ms.req.index_here) * 47'(a5);
         n2b5_ff     <= 47'(ms.req.index_beyond) * 47'(root);
         n2a5_ff     <= 47'(ms.req.index_beyond) * 47'(a5);
         n1b5_ff     <= 47'(ms.req.index_here) * 47'(root);

         m6_ff       <= m6_in;
         ds6_ff      <= ds6_in;
         dp6_ff      <= dp6_in;
         ns6_ff      <= (n1a5_ff > n2b5_ff) ? (n1a5_ff - n2b5_ff) : (n2b5_ff - n1a5_ff);
         np6_ff      <= (n2a5_ff > n1b5_ff) ? (n2a5_ff - n1b5_ff) : (n1b5_ff - n2a5_ff);

         m7_ff       <= m6_ff;
         ns7_ff      <= 32'({1'b0, ns6_ff} >> ks);
         ds7_ff      <= 32'(ds6_ff >> ks);
         np7_ff      <= 32'({1'b0, np6_ff} >> kp);
         dp7_ff      <= 32'(dp6_ff >> kp);

         m8_ff       <= md;
         rs8_ff      <= rs8_in;
         rp8_ff      <= rp8_in;
         qx8_ff      <= qx;
         qy8_ff      <= qy;
         ovfx8_ff    <= ovfx;
         ovfy8_ff    <= ovfy;

         rsp_data_ff <= rsp_in;
      end
   end

`ifndef ASSERT_OFF
   a_tir_reflects: assert property (@(posedge clock) disable iff (reset)
      (adv && v8_ff && (m8_ff.tir || m8_ff.req.index_beyond == 16'd0))
      |=> !rsp_data.transmitted)
      else $error("total internal reflection produced a transmission");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (!adv) |=> ($stable(v8_ff) && $stable(v4_ff) && $stable(v1_ff)))
      else $error("pipeline valid changed during stall");

   a_trans_z_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.transmitted)
      |-> (rsp_data.new_dir_z <= 32'sh4000_0000 && rsp_data.new_dir_z >= -32'sh4000_0000))
      else $error("transmitted z cosine out of range");
`endif

endmodule

>>> bench/fresnel_reflect_or_transmit_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fresnel_reflect_or_transmit_core_tb
// Drives photon boundary events into the Fresnel core and compares every
// response against an in-bench fixed-point model of Snell and Fresnel math,
// with idle and stall patterns on both channels.
// ----------------------------------------------------------------------------
module fresnel_reflect_or_transmit_core_tb
   import fresnel_pkg::*;
();

   localparam logic [63:0] Q30 = 64'h4000_0000;
   localparam logic [63:0] Q32 = 64'h1_0000_0000;
   localparam longint      MAXP = 64'sd2147483647;
   localparam longint      MINN = -64'sd2147483648;
   localparam int          LATENCY = 109;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   fresnel_req_type req_data;
   logic            rsp_valid;
   logic            rsp_ready;
   fresnel_rsp_type rsp_data;

   fresnel_rsp_type expected_events[$];
   int              error_count;
   int              send_idle_pct;
   int              recv_stall_pct;
   int              hold_cycles;

   fresnel_reflect_or_transmit_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic longint sat_w(longint v);
      if (v > MAXP) return MAXP;
      if (v < MINN) return MINN;
      return v;
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] r;
      logic [63:0] bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= r + bitv) begin
            x = x - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv = bitv >> 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] fresnel_term(logic [63:0] num, logic [63:0] den);
      logic [127:0] r;
      while ((den >> 32) != 0) begin
         num = num >> 1;
         den = den >> 1;
      end
      r = ({64'd0, num} << 32) / den;
      if (r >= Q32) return Q32;
      return 64'((r * r) >> 32);
   endfunction

   function automatic logic [63:0] diff_mag(logic [63:0] p, logic [63:0] q);
      return p > q ? p - q : q - p;
   endfunction

   function automatic longint scale_index(longint v, logic [63:0] n1, logic [63:0] n2);
      logic [63:0] mag;
      longint      s;
      mag = v < 0 ? 64'(-v) : 64'(v);
      s = longint'((mag * n1) / n2);
      return sat_w(v < 0 ? -s : s);
   endfunction

   function automatic fresnel_rsp_type predict_boundary(fresnel_req_type t);
      longint          x, y, z, nx, ny, nz;
      logic [63:0]     n1, n2, u, a, b, refl, s, q, ds, dp;
      fresnel_rsp_type o;
      x = longint'(t.dir_x);
      y = longint'(t.dir_y);
      z = longint'(t.dir_z);
      n1 = 64'(t.index_here);
      n2 = 64'(t.index_beyond);
      u = 64'(t.random_fraction);
      a = z < 0 ? 64'(-z) : 64'(z);
      if (a > Q30) a = Q30;
      refl = Q32;
      b = 0;
      if (n2 != 0) begin
         s = ((Q30 - a) * (Q30 + a)) >> 30;
         q = (n1 * n1 * s) / (n2 * n2);
         if (q <= Q30) begin
            b = int_sqrt((Q30 - q) << 30);
            ds = n1 * a + n2 * b;
            dp = n2 * a + n1 * b;
            if (ds != 0 && dp != 0)
               refl = (fresnel_term(diff_mag(n1 * a, n2 * b), ds) +
                       fresnel_term(diff_mag(n2 * a, n1 * b), dp)) >> 1;
         end
      end
      if (b > 64'(MAXP)) b = 64'(MAXP);
      if (u <= refl) begin
         o.new_dir_x = x[31:0];
         o.new_dir_y = y[31:0];
         nz = sat_w(-z);
         o.new_dir_z = nz[31:0];
         o.transmitted = 1'b0;
      end else begin
         nx = scale_index(x, n1, n2);
         ny = scale_index(y, n1, n2);
         nz = z > 0 ? longint'(b) : -longint'(b);
         o.new_dir_x = nx[31:0];
         o.new_dir_y = ny[31:0];
         o.new_dir_z = nz[31:0];
         o.transmitted = 1'b1;
      end
      return o;
   endfunction

   task automatic send_event(fresnel_req_type t);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      expected_events.push_back(predict_boundary(t));
      req_data <= t;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_cos();
      int unsigned k;
      k = $urandom_range(9);
      case (k)
         0: return 32'h4000_0000;
         1: return 32'hC000_0000;
         2: return 32'd0;
         3: return $urandom;
         default: return 32'($signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000);
      endcase
   endfunction

   function automatic fresnel_req_type rand_event();
      fresnel_req_type t;
      t.dir_x = rand_cos();
      t.dir_y = rand_cos();
      t.dir_z = rand_cos();
      t.index_here = $urandom_range(9) == 0 ? 16'($urandom) : 16'($urandom_range(4096, 12000));
      t.index_beyond = $urandom_range(9) == 0 ? 16'($urandom) : 16'($urandom_range(4096, 12000));
      t.random_fraction = $urandom;
      return t;
   endfunction

   task automatic test_directed();
      fresnel_req_type t;
      logic [31:0]     zs[6];
      zs = '{32'h4000_0000, 32'hC000_0000, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h2000_0000};
      foreach (zs[i]) begin
         t = '{32'h7FFF_FFFF, 32'h8000_0000, zs[i], 16'd6554, 16'd4096, 32'hFFFF_FFFF};
         send_event(t);
         t = '{32'h1000_0000, 32'hF000_0000, zs[i], 16'd4096, 16'd6554, 32'd0};
         send_event(t);
      end
      t = '{32'h1000_0000, 32'h1000_0000, 32'h1000_0000, 16'd8192, 16'd0, 32'hFFFF_FFFF};
      send_event(t);
      t = '{32'h1000_0000, 32'h1000_0000, 32'd0, 16'd0, 16'd4096, 32'hFFFF_FFFF};
      send_event(t);
      t = '{32'h1000_0000, 32'h1000_0000, 32'h0800_0000, 16'd8192, 16'd4096, 32'hFFFF_FFFF};
      send_event(t);
      t = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h3000_0000, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF};
      send_event(t);
      t = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hD000_0000, 16'hFFFF, 16'd4096, 32'h8000_0000};
      send_event(t);
      wait_drain();
   endtask

   task automatic test_random(int n, int idle, int stall);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      repeat (n) send_event(rand_event());
      wait_drain();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_cycles = 300;
      repeat (200) send_event(rand_event());
      wait_drain();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      fresnel_rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_events.size() == 0) begin
            $error("unexpected transaction %h", rsp_data);
            error_count++;
         end else begin
            e = expected_events.pop_front();
            if (rsp_data.new_dir_x !== e.new_dir_x) begin
               $error("new_dir_x exp %h got %h", e.new_dir_x, rsp_data.new_dir_x);
               error_count++;
            end
            if (rsp_data.new_dir_y !== e.new_dir_y) begin
               $error("new_dir_y exp %h got %h", e.new_dir_y, rsp_data.new_dir_y);
               error_count++;
            end
            if (rsp_data.new_dir_z !== e.new_dir_z) begin
               $error("new_dir_z exp %h got %h", e.new_dir_z, rsp_data.new_dir_z);
               error_count++;
            end
            if (rsp_data.transmitted !== e.transmitted) begin
               $error("transmitted exp %b got %b", e.transmitted, rsp_data.transmitted);
               error_count++;
            end
         end
      end
   end

   initial begin
      error_count = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_cycles = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(100, 0, 0);
      test_random(110, 69, 0);
      test_random(110, 0, 69);
      test_random(110, 12, 12);
      test_backpressure();
      repeat (LATENCY + 20) @(posedge clock);
      if (error_count == 0 && expected_events.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

>>> files.f
design/fresnel_pkg.sv
design/fresnel_div.sv
design/fresnel_isqrt.sv
design/fresnel_reflect_or_transmit_core.sv
bench/fresnel_reflect_or_transmit_core_tb.sv
